[src/box_blur_rgb_macros.svh]
// Assertion helpers shared by the box blur modules.
`ifndef BOX_BLUR_RGB_MACROS_SVH
`define BOX_BLUR_RGB_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define BBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define BBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);

`endif

[src/bbr_pkg.sv]
`timescale 1ns / 1ps
package bbr_pkg;

    localparam int MAX_RADIUS_DEF = 15;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // coordinate, slot and radius widths cover the full parameter ranges
    localparam int CW  = 13;
    localparam int SLW = 6;
    localparam int RDW = 5;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic [RDW-1:0] radius;
        logic [CW-1:0]  width;
        logic [CW-1:0]  height;
    } t_geom;

    typedef struct packed {
        logic [CW-1:0]  ox;
        logic [CW-1:0]  oy;
        logic [SLW-1:0] slot;
        logic           last;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUM,
        BK_WAIT,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

[src/bbr_ram.sv]
`timescale 1ns / 1ps
module bbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/bbr_front.sv]
`timescale 1ns / 1ps
module bbr_front import bbr_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int ROWS       = 2 * MAX_RADIUS + 2,
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int SLTB       = $clog2(ROWS),
    parameter int AW         = $clog2(ROWS * (2 ** XW))
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_geom         i_geom,
    input  logic          i_cfg_hit,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_item      i_in_item,
    input  logic          i_pending,
    input  logic          i_q_full,
    output logic          o_push,
    output t_job          o_job,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [23:0]   o_wdata
);

    logic [CW-1:0]  r_in_x, r_in_y, r_out_x, r_out_y;
    logic [SLW-1:0] r_in_slot, r_out_slot;
    logic [CW-1:0]  n_in_x, n_in_y, n_out_x, n_out_y;
    logic [SLW-1:0] n_in_slot, n_out_slot;

    logic           accept, do_write, emit, last;
    logic [CW-1:0]  w_m1, h_m1, rad, a_x, a_y, nx, ny;
    logic [SLW-1:0] a_slot;

    // pixels wait while any job still reads the row store
    assign o_in_stall = i_q_full || (i_pending && (i_in_item.op == OP_PIXEL));
    assign accept     = i_in_valid && !o_in_stall;
    assign do_write   = accept && (i_in_item.op == OP_PIXEL) && (r_in_y < i_geom.height);

    assign w_m1 = i_geom.width - CW'(1);
    assign h_m1 = i_geom.height - CW'(1);
    assign rad  = CW'(i_geom.radius);

    always_comb begin
        a_x    = r_in_x;
        a_y    = r_in_y;
        a_slot = r_in_slot;
        if (do_write) begin
            if (r_in_x == w_m1) begin
                a_x    = '0;
                a_y    = r_in_y + CW'(1);
                a_slot = (r_in_slot == SLW'(ROWS - 1)) ? '0 : r_in_slot + SLW'(1);
            end else begin
                a_x = r_in_x + CW'(1);
            end
        end
    end

    assign nx   = (r_out_x + rad > w_m1) ? w_m1 : r_out_x + rad;
    assign ny   = (r_out_y + rad > h_m1) ? h_m1 : r_out_y + rad;
    assign emit = accept && ((a_y > ny) || ((a_y == ny) && (a_x > nx)));
    assign last = (r_out_x == w_m1) && (r_out_y == h_m1);

    assign o_push  = emit;
    assign o_job   = '{ox: r_out_x, oy: r_out_y, slot: r_out_slot, last: last};
    assign o_we    = do_write;
    assign o_waddr = AW'({r_in_slot[SLTB-1:0], r_in_x[XW-1:0]});
    assign o_wdata = {i_in_item.red_in, i_in_item.green_in, i_in_item.blue_in};

    always_comb begin
        n_in_x     = a_x;
        n_in_y     = a_y;
        n_in_slot  = a_slot;
        n_out_x    = r_out_x;
        n_out_y    = r_out_y;
        n_out_slot = r_out_slot;
        priority if (i_cfg_hit || (emit && last)) begin
            n_in_x     = '0;
            n_in_y     = '0;
            n_in_slot  = '0;
            n_out_x    = '0;
            n_out_y    = '0;
            n_out_slot = '0;
        end else if (emit) begin
            if (r_out_x == w_m1) begin
                n_out_x    = '0;
                n_out_y    = r_out_y + CW'(1);
                n_out_slot = (r_out_slot == SLW'(ROWS - 1)) ? '0 : r_out_slot + SLW'(1);
            end else begin
                n_out_x = r_out_x + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_x     <= '0;
            r_in_y     <= '0;
            r_in_slot  <= '0;
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_out_slot <= '0;
        end else begin
            r_in_x     <= n_in_x;
            r_in_y     <= n_in_y;
            r_in_slot  <= n_in_slot;
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_slot <= n_out_slot;
        end
    end

endmodule

[src/bbr_fifo.sv]
`timescale 1ns / 1ps
`include "box_blur_rgb_macros.svh"
module bbr_fifo import bbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `BBR_ASSERT(a_no_overflow, (i_push |-> !o_full), "job queue overflow")
    `BBR_ASSERT(a_no_underflow, (i_pop |-> !o_empty), "job queue underflow")
    `BBR_ASSERT(a_cnt_range, (r_cnt <= 2'd2), "job queue count out of range")

endmodule

[src/bbr_back.sv]
`timescale 1ns / 1ps
`include "box_blur_rgb_macros.svh"
module bbr_back import bbr_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int ROWS       = 2 * MAX_RADIUS + 2,
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int SLTB       = $clog2(ROWS),
    parameter int AW         = $clog2(ROWS * (2 ** XW))
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_geom         i_geom,
    input  t_job          i_job,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [23:0]   i_rdata,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out_item     o_out_item,
    output logic          o_busy
);

    localparam int WIN  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int SW   = $clog2(WIN * 255 + 1);
    localparam int DVW  = $clog2(WIN + 1);
    localparam int CNTW = $clog2(SW);

    t_back_state r_state, n_state;

    logic [CW-1:0]   r_x, r_y, r_x0, r_x1, r_y1;
    logic [SLW-1:0]  r_slot;
    logic            r_last, r_rd_v;
    logic [DVW-1:0]  r_div;
    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_acc [3];
    logic [DVW-1:0]  r_rem [3];

    logic [CW-1:0]   rad, w_m1, h_m1, j_x0, j_x1, j_y0, j_y1, j_d;
    logic [SLW-1:0]  j_slot;
    logic [5:0]      side;
    logic [11:0]     side_sq;
    logic [DVW:0]    trial [3];
    logic            ge [3];

    assign rad  = CW'(i_geom.radius);
    assign w_m1 = i_geom.width - CW'(1);
    assign h_m1 = i_geom.height - CW'(1);

    // window bounds clipped to the image
    assign j_x0 = (i_job.ox > rad) ? i_job.ox - rad : '0;
    assign j_y0 = (i_job.oy > rad) ? i_job.oy - rad : '0;
    assign j_x1 = (i_job.ox + rad > w_m1) ? w_m1 : i_job.ox + rad;
    assign j_y1 = (i_job.oy + rad > h_m1) ? h_m1 : i_job.oy + rad;
    assign j_d  = i_job.oy - j_y0;
    // step the row slot back to the top of the window, wrapping around the ring
    assign j_slot = (CW'(i_job.slot) >= j_d) ? SLW'(CW'(i_job.slot) - j_d)
                                             : SLW'(CW'(i_job.slot) + CW'(ROWS) - j_d);

    assign side    = {i_geom.radius, 1'b1};
    assign side_sq = 12'(side) * 12'(side);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {r_rem[c], r_acc[c][SW-1]};
            ge[c]    = (trial[c] >= {1'b0, r_div});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_job_valid) n_state = BK_SUM;
            BK_SUM:  if ((r_x == r_x1) && (r_y == r_y1)) n_state = BK_WAIT;
            BK_WAIT: n_state = BK_DIV;
            BK_DIV:  if (r_cnt == '0) n_state = BK_OUT;
            BK_OUT:  if (!i_out_stall) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop   = (r_state == BK_IDLE) && i_job_valid;
        o_re        = (r_state == BK_SUM);
        o_out_valid = (r_state == BK_OUT);
        o_busy      = (r_state != BK_IDLE);
    end

    assign o_raddr = AW'({r_slot[SLTB-1:0], r_x[XW-1:0]});

    assign o_out_item = '{red_out: r_acc[0][7:0], green_out: r_acc[1][7:0],
                          blue_out: r_acc[2][7:0], frame_last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == BK_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    r_x    <= j_x0;
                    r_x0   <= j_x0;
                    r_x1   <= j_x1;
                    r_y    <= j_y0;
                    r_y1   <= j_y1;
                    r_slot <= j_slot;
                    r_last <= i_job.last;
                    r_div  <= DVW'(side_sq);
                    for (int c = 0; c < 3; c++) begin
                        r_acc[c] <= '0;
                    end
                end
            end
            BK_SUM, BK_WAIT: begin
                // data arrives in the cycle after its address
                if (r_rd_v) begin
                    for (int c = 0; c < 3; c++) begin
                        r_acc[c] <= r_acc[c] + SW'(i_rdata[8*(2-c) +: 8]);
                    end
                end
                if (r_state == BK_SUM) begin
                    if (r_x == r_x1) begin
                        r_x <= r_x0;
                        if (r_y != r_y1) begin
                            r_y    <= r_y + CW'(1);
                            r_slot <= (r_slot == SLW'(ROWS - 1)) ? '0 : r_slot + SLW'(1);
                        end
                    end else begin
                        r_x <= r_x + CW'(1);
                    end
                end else begin
                    r_cnt <= CNTW'(SW - 1);
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c] <= '0;
                    end
                end
            end
            BK_DIV: begin
                // one quotient bit per cycle, shifted into the sum register
                for (int c = 0; c < 3; c++) begin
                    r_rem[c] <= ge[c] ? DVW'(trial[c] - {1'b0, r_div}) : DVW'(trial[c]);
                    r_acc[c] <= {r_acc[c][SW-2:0], ge[c]};
                end
                r_cnt <= r_cnt - CNTW'(1);
            end
            BK_OUT: ;
            default: ;
        endcase
    end

    `BBR_ASSERT(a_x_in_window, (r_state == BK_SUM |-> (r_x >= r_x0) && (r_x <= r_x1)),
                "read column outside window")
    `BBR_ASSERT(a_rem_below_div, (r_state == BK_DIV |-> r_rem[0] < r_div),
                "divider remainder out of range")
    `BBR_ASSERT_NEXT(a_wait_to_div, (r_state == BK_WAIT), (r_state == BK_DIV),
                "sum did not hand over to divider")

endmodule

[src/box_blur_rgb.sv]
`timescale 1ns / 1ps
// Box blur over an RGB raster stream, zero padded, divisor always (2r+1)^2.
// Input channel: i_in_valid / o_in_stall with i_in_item. op selects a pixel
// or a flush tick; flush ticks push out the results that trail the last pixel.
// Output channel: o_out_valid / i_out_stall with o_out_item; frame_last marks
// the final result of a frame. Config: i_cfg_valid / o_cfg_ready (always high)
// with register index 0 radius, 1 width, 2 height; a write restarts the frame.
// The front writes pixels into a ring of 2*MAX_RADIUS+2 rows (the window plus
// the row written while its results drain) and queues one job per result that
// becomes ready; the back reads the clipped window from the row store one
// pixel per cycle, then divides with a bit-serial divider.
// Per result the back steps through idle, sum, wait, divide and output, the
// window being at most (2r+1)^2 pixels. Pixels are held off while a job is
// queued or in work; flush ticks are taken as long as the job queue has room.
// A stalled result is held in the back, which waits with it.
// Reset: radius 10, 600 x 600 image, empty queue, frame at its first pixel;
// no clearing pass is needed.
module box_blur_rgb import bbr_pkg::*; #(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int ROWS  = 2 * MAX_RADIUS + 2;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = ROWS * (2 ** XW);
    localparam int AW    = $clog2(DEPTH);

    logic [3:0]  r_radius;
    logic [10:0] r_width, r_height;
    t_geom       geom;
    logic        cfg_hit;

    logic          q_push, q_pop, q_empty, q_full, back_busy;
    t_job          push_job, head_job;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   wdata, rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && ((i_cfg_index == CFG_RADIUS) ||
                     (i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 4'd10;
            r_width  <= 11'd600;
            r_height <= 11'd600;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS: r_radius <= i_cfg_data[3:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate the registers into the supported ranges
    always_comb begin
        geom.radius = (32'(r_radius) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(r_radius);
        if (r_width == '0) begin
            geom.width = CW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            geom.width = CW'(MAX_WIDTH);
        end else begin
            geom.width = CW'(r_width);
        end
        if (r_height == '0) begin
            geom.height = CW'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            geom.height = CW'(MAX_HEIGHT);
        end else begin
            geom.height = CW'(r_height);
        end
    end

    bbr_front #(
        .MAX_RADIUS(MAX_RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_cfg_hit (cfg_hit),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item (i_in_item),
        .i_pending (back_busy || !q_empty),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_job     (push_job),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    bbr_ram #(
        .WIDTH(24),
        .DEPTH(DEPTH)
    ) u_row_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    bbr_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (push_job),
        .i_pop  (q_pop),
        .o_job  (head_job),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    bbr_back #(
        .MAX_RADIUS(MAX_RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_job      (head_job),
        .i_job_valid(!q_empty),
        .o_job_pop  (q_pop),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .o_busy     (back_busy)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import bbr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 1100;
    localparam int RAND_PIXELS = 1500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    box_blur_rgb i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // blur predictor state
    logic [3:0]  radius_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    int          pix_in_pos;
    int          pix_out_pos;
    logic [23:0] frame_px [int];

    t_out_item mean_q[$];
    int        n_errors;
    int        n_results;
    int        n_pixels;
    int        n_flushes;
    int        n_writes;
    bit        send_quiet;
    bit        recv_quiet;
    int        stall_left;

    function automatic int clamp_dim(input logic [10:0] v, input int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic bit blur_step(input t_in_item it, output t_out_item res);
        int r, w, h, total, ox, oy, nx, ny, x0, y0, sr, sg, sb, dv;
        r = radius_reg;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        total = w * h;
        res = '0;
        if (it.op == OP_PIXEL && pix_in_pos < total) begin
            frame_px[pix_in_pos] = {it.red_in, it.green_in, it.blue_in};
            pix_in_pos++;
        end
        if (pix_out_pos >= total) return 1'b0;
        ox = pix_out_pos % w;
        oy = pix_out_pos / w;
        nx = (ox + r > w - 1) ? w - 1 : ox + r;
        ny = (oy + r > h - 1) ? h - 1 : oy + r;
        if (pix_in_pos <= ny * w + nx) return 1'b0;
        x0 = (ox - r < 0) ? 0 : ox - r;
        y0 = (oy - r < 0) ? 0 : oy - r;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int yy = y0; yy <= ny; yy++) begin
            for (int xx = x0; xx <= nx; xx++) begin
                sr += frame_px[yy * w + xx][23:16];
                sg += frame_px[yy * w + xx][15:8];
                sb += frame_px[yy * w + xx][7:0];
            end
        end
        dv = (2 * r + 1) * (2 * r + 1);
        res.red_out   = 8'(sr / dv);
        res.green_out = 8'(sg / dv);
        res.blue_out  = 8'(sb / dv);
        pix_out_pos++;
        if (pix_out_pos == total) begin
            res.frame_last = 1'b1;
            pix_in_pos = 0;
            pix_out_pos = 0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string tag, input t_out_item exp_v,
                                   input t_out_item got_v);
        n_errors++;
        if (n_errors <= 10)
            $display("%s mismatch: expected %h %h %h last %b, got %h %h %h last %b", tag,
                     exp_v.red_out, exp_v.green_out, exp_v.blue_out, exp_v.frame_last,
                     got_v.red_out, got_v.green_out, got_v.blue_out, got_v.frame_last);
    endtask

    // send one item; returns the prediction for it
    task automatic send_item(input t_in_item it, output bit got, output t_out_item res);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        got = blur_step(it, res);
        if (got) mean_q.push_back(res);
        if (it.op == OP_PIXEL) n_pixels++;
        else n_flushes++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (mean_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RADIUS: radius_reg = data[3:0];
            CFG_WIDTH:  width_reg  = data;
            CFG_HEIGHT: height_reg = data;
            default: ;
        endcase
        if (idx != CFG_UNUSED) begin
            pix_in_pos = 0;
            pix_out_pos = 0;
        end
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            stall_left = recv_quiet ? 0 : $urandom_range(0, 7);
            if (mean_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %h", o_out_item);
            end else begin
                t_out_item exp_v;
                exp_v = mean_q.pop_front();
                if (o_out_item.red_out != exp_v.red_out
                        || o_out_item.green_out != exp_v.green_out
                        || o_out_item.blue_out != exp_v.blue_out
                        || o_out_item.frame_last != exp_v.frame_last)
                    report_mismatch("result", exp_v, o_out_item);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [10:0] data;
        t_in_item    it;
        bit          has_exp;
        t_out_item   exp_v;
    } t_step_row;

    function automatic t_step_row cfg_row(input logic [1:0] idx, input logic [10:0] data);
        t_step_row s;
        s = '{1'b1, idx, data, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic t_step_row px_row(input logic op, input logic [23:0] rgb,
                                         input bit has_exp, input logic [24:0] exp_bits);
        t_step_row s;
        s = '{1'b0, 2'd0, 11'd0, {op, rgb}, has_exp, exp_bits};
        return s;
    endfunction

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_step_row  steps[$];
        t_in_item   it;
        t_out_item  res;
        bit         got;
        int         w, h, total, n_frames, rd;
        bit         abandon;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RADIUS;
        i_cfg_data = '0;
        stall_left = 0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        n_errors = 0;
        n_results = 0;
        n_pixels = 0;
        n_flushes = 0;
        n_writes = 0;
        radius_reg = 4'd10;
        width_reg = 11'd600;
        height_reg = 11'd600;
        pix_in_pos = 0;
        pix_out_pos = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single pixel image at radius zero: output equals input
        steps.push_back(cfg_row(CFG_RADIUS, 11'd0));
        steps.push_back(cfg_row(CFG_WIDTH, 11'd0));
        steps.push_back(cfg_row(CFG_HEIGHT, 11'd0));
        steps.push_back(px_row(OP_PIXEL, 24'hFF00FF, 1'b1, {24'hFF00FF, 1'b1}));
        steps.push_back(px_row(OP_PIXEL, 24'h00FF00, 1'b1, {24'h00FF00, 1'b1}));
        steps.push_back(px_row(OP_FLUSH, 24'hFFFFFF, 1'b0, '0));
        // saturated radius on a 3x2 white image: 6*255/961 everywhere
        steps.push_back(cfg_row(CFG_RADIUS, 11'h7FF));
        steps.push_back(cfg_row(CFG_WIDTH, 11'd3));
        steps.push_back(cfg_row(CFG_HEIGHT, 11'd2));
        for (int k = 0; k < 5; k++)
            steps.push_back(px_row(OP_PIXEL, 24'hFFFFFF, 1'b0, '0));
        steps.push_back(px_row(OP_PIXEL, 24'hFFFFFF, 1'b1, {24'h010101, 1'b0}));
        // excess pixels are dropped but still drain one result each
        steps.push_back(px_row(OP_PIXEL, 24'h000000, 1'b1, {24'h010101, 1'b0}));
        steps.push_back(px_row(OP_PIXEL, 24'h000000, 1'b1, {24'h010101, 1'b0}));
        steps.push_back(px_row(OP_FLUSH, 24'h0, 1'b1, {24'h010101, 1'b0}));
        steps.push_back(px_row(OP_FLUSH, 24'h0, 1'b1, {24'h010101, 1'b0}));
        steps.push_back(px_row(OP_FLUSH, 24'h0, 1'b1, {24'h010101, 1'b1}));
        steps.push_back(cfg_row(CFG_UNUSED, 11'd5));
        // wide single row, partial frame, then abandoned by a write
        steps.push_back(cfg_row(CFG_WIDTH, 11'h7FF));
        steps.push_back(cfg_row(CFG_HEIGHT, 11'd1));
        steps.push_back(px_row(OP_PIXEL, 24'h123456, 1'b0, '0));
        steps.push_back(px_row(OP_PIXEL, 24'hABCDEF, 1'b0, '0));
        steps.push_back(px_row(OP_PIXEL, 24'h5A5AA5, 1'b0, '0));
        steps.push_back(cfg_row(CFG_RADIUS, 11'd1));

        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                settle();
                write_reg(steps[i].idx, steps[i].data);
            end else begin
                send_item(steps[i].it, got, res);
                if (steps[i].has_exp && (!got || res != steps[i].exp_v))
                    report_mismatch("directed", steps[i].exp_v, res);
            end
        end

        // random phases: mostly small images and radii, a few extremes
        while (n_pixels + n_flushes < RAND_PIXELS) begin
            settle();
            send_quiet = ($urandom_range(0, 4) == 0);
            recv_quiet = ($urandom_range(0, 4) == 0);
            rd = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            case ($urandom_range(0, 29))
                0: begin w = 1024; h = 1; end
                1: begin w = 1; h = 1024; rd = $urandom_range(0, 3); end
                2: begin w = 1; h = 1; end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 11'($urandom));
            write_reg(CFG_WIDTH, (w == 1024 && $urandom_range(0, 1)) ? 11'h7FF : 11'(w));
            write_reg(CFG_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? 11'd0 : 11'(h));
            write_reg(CFG_RADIUS, {$urandom_range(0, 1) ? 7'h7F : 7'h00, 4'(rd)});
            total = w * h;
            n_frames = (total > 200) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                abandon = ($urandom_range(0, 9) == 0);
                for (int p = 0; p < total; p++) begin
                    if (abandon && p == total / 2) break;
                    if ($urandom_range(0, 19) == 0) begin
                        it = {OP_FLUSH, 24'($urandom)};
                        send_item(it, got, res);
                    end
                    case ($urandom_range(0, 7))
                        0: it = {OP_PIXEL, 24'h000000};
                        1: it = {OP_PIXEL, 24'hFFFFFF};
                        default: it = {OP_PIXEL, 24'($urandom)};
                    endcase
                    send_item(it, got, res);
                end
                if (abandon) break;
                // drain the trailing results, with a stray excess pixel now and then
                while (pix_in_pos != 0 || pix_out_pos != 0) begin
                    if ($urandom_range(0, 9) == 0) it = {OP_PIXEL, 24'($urandom)};
                    else it = {OP_FLUSH, 24'($urandom)};
                    send_item(it, got, res);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (mean_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d pixels, %0d flush ticks, %0d register writes", n_pixels,
                 n_flushes, n_writes);
        $display("checked %0d blurred results, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && mean_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/bbr_pkg.sv
src/bbr_ram.sv
src/bbr_front.sv
src/bbr_fifo.sv
src/bbr_back.sv
src/box_blur_rgb.sv
tb/tb.sv
